// File: src/json_string_unescape_utf8_defines.svh
//------------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared concurrent assertion forms used by the decoder's modules.
//------------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/jsu_pkg.sv
//------------------------------------------------------------------------------
// JSON string unescaper package
// Types, codes and constants shared by the front end, queue and back end.
//------------------------------------------------------------------------------
package jsu_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned CP_WIDTH = 21;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CTRL_BACKSPACE = 8'h08;
   localparam logic [7:0] CTRL_FORMFEED  = 8'h0C;
   localparam logic [7:0] CTRL_NEWLINE   = 8'h0A;
   localparam logic [7:0] CTRL_RETURN    = 8'h0D;
   localparam logic [7:0] CTRL_TAB       = 8'h09;

   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
   localparam logic [5:0]  LOW_SURR_PREFIX = 6'b110111;
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_BODY   = 3'd1,
      MODE_ESC    = 3'd2,
      MODE_HEX1   = 3'd3,
      MODE_WANTBS = 3'd4,
      MODE_WANTU  = 3'd5,
      MODE_HEX2   = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_NO_OPEN      = 3'd1,
      ERR_END_STRING   = 3'd2,
      ERR_END_ESCAPE   = 3'd3,
      ERR_BAD_UNICODE  = 3'd4,
      ERR_BAD_SURROGATE = 3'd5,
      ERR_BAD_ESCAPE   = 3'd6
   } err_type;

   typedef enum logic [1:0] {
      CMD_BYTE       = 2'd0,
      CMD_CODE_POINT = 2'd1,
      CMD_DONE       = 2'd2,
      CMD_ERROR      = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [CP_WIDTH-1:0]   value;
      err_type               err;
   } cmd_type;

endpackage

// File: src/jsu_front.sv
//------------------------------------------------------------------------------
// JSON string unescaper front end
// Accepts raw bytes, tracks the escape state and queues one command per
// byte that yields output.
//------------------------------------------------------------------------------
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_at_end,
   input  logic             queue_full,
   output logic             push_valid,
   output jsu_pkg::cmd_type push_data
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] hex_acc_ff, hex_acc_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [9:0]  hi_sur_ff, hi_sur_in;

   logic        accept;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] hex_next;
   logic        emit;
   cmd_type     cmd;
   err_type     hex_err;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;
   assign {hex_ok, hex_val} = hex_decode(req_data_byte);
   assign hex_next = {hex_acc_ff[11:0], hex_val};
   assign hex_err = (mode_ff == MODE_HEX1) ? ERR_BAD_UNICODE : ERR_BAD_SURROGATE;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         hex_acc_ff <= '0;
         hex_cnt_ff <= '0;
         hi_sur_ff  <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         hex_acc_ff <= hex_acc_in;
         hex_cnt_ff <= hex_cnt_in;
         hi_sur_ff  <= hi_sur_in;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      hex_acc_in = hex_acc_ff;
      hex_cnt_in = hex_cnt_ff;
      hi_sur_in  = hi_sur_ff;
      emit       = 1'b0;
      cmd.kind   = CMD_BYTE;
      cmd.value  = {13'd0, req_data_byte};
      cmd.err    = ERR_NONE;
      unique case (mode_ff)
         MODE_BODY: begin
            if (req_at_end) begin
               emit = 1'b1; cmd.kind = CMD_ERROR; cmd.err = ERR_END_STRING;
               mode_in = MODE_IDLE;
            end else if (req_data_byte == CHAR_QUOTE) begin
               emit = 1'b1; cmd.kind = CMD_DONE;
               mode_in = MODE_IDLE;
            end else if (req_data_byte == CHAR_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               emit = 1'b1;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_BODY;
            emit = 1'b1;
            if (req_at_end) begin
               cmd.kind = CMD_ERROR; cmd.err = ERR_END_ESCAPE;
               mode_in = MODE_IDLE;
            end else begin
               unique case (req_data_byte)
                  CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: cmd.value = {13'd0, req_data_byte};
                  CHAR_LOWER_B: cmd.value = {13'd0, CTRL_BACKSPACE};
                  CHAR_LOWER_F: cmd.value = {13'd0, CTRL_FORMFEED};
                  CHAR_LOWER_N: cmd.value = {13'd0, CTRL_NEWLINE};
                  CHAR_LOWER_R: cmd.value = {13'd0, CTRL_RETURN};
                  CHAR_LOWER_T: cmd.value = {13'd0, CTRL_TAB};
                  CHAR_LOWER_U: begin
                     emit = 1'b0;
                     mode_in = MODE_HEX1;
                     hex_acc_in = '0;
                     hex_cnt_in = '0;
                  end
                  default: begin
                     cmd.kind = CMD_ERROR; cmd.err = ERR_BAD_ESCAPE;
                     mode_in = MODE_IDLE;
                  end
               endcase
            end
         end
         MODE_HEX1, MODE_HEX2: begin
            if (req_at_end || !hex_ok) begin
               emit = 1'b1; cmd.kind = CMD_ERROR; cmd.err = hex_err;
               mode_in = MODE_IDLE;
            end else begin
               hex_acc_in = hex_next;
               if (hex_cnt_ff != 2'd3) begin
                  hex_cnt_in = hex_cnt_ff + 2'd1;
               end else begin
                  hex_cnt_in = '0;
                  if (mode_ff == MODE_HEX1) begin
                     if (hex_next >= HIGH_SURR_FIRST && hex_next <= HIGH_SURR_LAST) begin
                        hi_sur_in = hex_next[9:0];
                        mode_in = MODE_WANTBS;
                     end else begin
                        emit = 1'b1; cmd.kind = CMD_CODE_POINT;
                        cmd.value = {5'd0, hex_next};
                        mode_in = MODE_BODY;
                     end
                  end else if (hex_next[15:10] != LOW_SURR_PREFIX) begin
                     emit = 1'b1; cmd.kind = CMD_ERROR; cmd.err = ERR_BAD_SURROGATE;
                     mode_in = MODE_IDLE;
                  end else begin
                     emit = 1'b1; cmd.kind = CMD_CODE_POINT;
                     cmd.value = SUPPLEMENTARY_BASE + {1'b0, hi_sur_ff, hex_next[9:0]};
                     mode_in = MODE_BODY;
                  end
               end
            end
         end
         MODE_WANTBS: begin
            if (req_at_end || req_data_byte != CHAR_BACKSLASH) begin
               emit = 1'b1; cmd.kind = CMD_ERROR; cmd.err = ERR_BAD_SURROGATE;
               mode_in = MODE_IDLE;
            end else begin
               mode_in = MODE_WANTU;
            end
         end
         MODE_WANTU: begin
            if (req_at_end || req_data_byte != CHAR_LOWER_U) begin
               emit = 1'b1; cmd.kind = CMD_ERROR; cmd.err = ERR_BAD_SURROGATE;
               mode_in = MODE_IDLE;
            end else begin
               mode_in = MODE_HEX2;
               hex_acc_in = '0;
               hex_cnt_in = '0;
            end
         end
         default: begin
            if (req_at_end || req_data_byte != CHAR_QUOTE) begin
               emit = 1'b1; cmd.kind = CMD_ERROR; cmd.err = ERR_NO_OPEN;
               mode_in = MODE_IDLE;
            end else begin
               mode_in = MODE_BODY;
            end
         end
      endcase
   end

   assign push_valid = accept && emit;
   assign push_data  = cmd;

endmodule

// File: src/jsu_queue.sv
//------------------------------------------------------------------------------
// JSON string unescaper command queue
// A small first-in first-out buffer of decoded commands between the front
// end and the back end.
//------------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_queue #(
   parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  jsu_pkg::cmd_type push_data,
   output logic             full,
   output logic             head_valid,
   output jsu_pkg::cmd_type head_data,
   input  logic             pop
);
   import jsu_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push_valid) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `JSU_ASSERT_IMP(a_no_overflow, clock, reset, push_valid, !full, "push into a full queue")
   `JSU_ASSERT_IMP(a_no_underflow, clock, reset, pop, head_valid, "pop from an empty queue")
   `JSU_ASSERT_NEXT(a_count_tracks, clock, reset, push_valid && !pop, count_ff != '0,
      "queue count lost a pushed command")

endmodule

// File: src/jsu_back.sv
//------------------------------------------------------------------------------
// JSON string unescaper back end
// Expands queued commands into result transactions, one UTF-8 byte per
// cycle while the output is not stalled, through a registered output stage.
//------------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::cmd_type head_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_string_done,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_last_of_run
);
   import jsu_pkg::*;

   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       out_byte_ff;
   logic             byte_valid_ff;
   logic             string_done_ff;
   logic [2:0]       error_code_ff;
   logic             last_ff;

   logic [3:0][7:0]  enc_bytes;
   logic [1:0]       last_idx;
   logic             load;
   logic             is_last;
   logic [20:0]      cp;

   assign cp = head_data.value;

   always_comb begin
      enc_bytes = '0;
      last_idx  = 2'd0;
      if (head_data.kind == CMD_CODE_POINT) begin
         if (cp <= 21'h7F) begin
            enc_bytes[0] = cp[7:0];
         end else if (cp <= 21'h7FF) begin
            last_idx = 2'd1;
            enc_bytes[0] = {3'b110, cp[10:6]};
            enc_bytes[1] = {2'b10, cp[5:0]};
         end else if (cp <= 21'hFFFF) begin
            last_idx = 2'd2;
            enc_bytes[0] = {4'b1110, cp[15:12]};
            enc_bytes[1] = {2'b10, cp[11:6]};
            enc_bytes[2] = {2'b10, cp[5:0]};
         end else begin
            last_idx = 2'd3;
            enc_bytes[0] = {5'b11110, cp[20:18]};
            enc_bytes[1] = {2'b10, cp[17:12]};
            enc_bytes[2] = {2'b10, cp[11:6]};
            enc_bytes[3] = {2'b10, cp[5:0]};
         end
      end else if (head_data.kind == CMD_BYTE) begin
         enc_bytes[0] = cp[7:0];
      end
   end

   assign load    = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign is_last = (idx_ff == last_idx);
   assign pop     = load && is_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff    <= enc_bytes[idx_ff];
         byte_valid_ff  <= (head_data.kind == CMD_BYTE) || (head_data.kind == CMD_CODE_POINT);
         string_done_ff <= (head_data.kind == CMD_DONE);
         error_code_ff  <= (head_data.kind == CMD_ERROR) ? head_data.err : ERR_NONE;
         last_ff        <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_byte_valid  = byte_valid_ff;
   assign rsp_string_done = string_done_ff;
   assign rsp_error_code  = error_code_ff;
   assign rsp_last_of_run = last_ff;

   `JSU_ASSERT_IMP(a_expansion_holds_head, clock, reset, idx_ff != 2'd0, head_valid,
      "command left the queue before all its bytes were sent")
   `JSU_ASSERT_IMP(a_status_is_last, clock, reset, rsp_valid_ff && !rsp_byte_valid,
      rsp_last_of_run, "done or error result not marked last")
   `JSU_ASSERT_IMP(a_byte_no_status, clock, reset, rsp_valid_ff && rsp_byte_valid,
      !rsp_string_done && rsp_error_code == ERR_NONE, "byte result carries status")

endmodule

// File: src/json_string_unescape_utf8.sv
//------------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     data_byte, at_end
//   rsp      out        rsp_valid/stall     out_byte, byte_valid, string_done,
//                                           error_code, last_of_run
//
// One request transaction is taken per cycle while the command queue has room.
// Each command leaves as one to four response transactions, one per cycle
// while the response is not stalled; a code point escape with an n-byte
// encoding stays at the queue head until all its bytes are sent.
// Reset is synchronous and clears the decode state, the queue and the output valid flag.
// A stalled response holds; the queue fills and then stalls requests.
//------------------------------------------------------------------------------
module json_string_unescape_utf8 #(
   parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_at_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_done,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last_of_run
);
   import jsu_pkg::*;

   logic    push_valid;
   cmd_type push_data;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_data;
   logic    pop;

   jsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_at_end    (req_at_end),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
